>>> hw/rtl/directive_config_lexer_macros.svh
// Assertion macros for the directive config lexer.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef DIRECTIVE_CONFIG_LEXER_MACROS_SVH
`define DIRECTIVE_CONFIG_LEXER_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define DCL_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("directive_config_lexer: same-cycle check failed");

// next-cycle implication
`define DCL_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("directive_config_lexer: next-cycle check failed");

`else

`define DCL_ASSERT_IMP(label, clk, rst, ante, cons)
`define DCL_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

>>> hw/rtl/dcl_pkg.sv
// Shared types and constants of the directive config lexer.
// Used by the front, queue, back and top modules; depends on nothing.
`timescale 1ns / 1ps

package dcl_pkg;

   // width of the internal newline counter and of the reported line number
   localparam int LINE_BITS     = 24;
   localparam int LINE_OUT_BITS = 24;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // stream widths
   localparam int REQ_DATA_BITS = 8;
   localparam int RSP_DATA_BITS = 8 + LINE_OUT_BITS;
   localparam int RSP_USER_BITS = 3;

   typedef enum logic [2:0] {
      EV_CHAR  = 3'd0,
      EV_WEND  = 3'd1,
      EV_STMT  = 3'd2,
      EV_BLOCK = 3'd3,
      EV_DONE  = 3'd4,
      EV_END   = 3'd5,
      EV_ERR   = 3'd6
   } event_kind_type;

   // one or two events caused by a single input word
   typedef struct packed {
      event_kind_type           kind0;
      logic [7:0]               char0;
      event_kind_type           kind1;
      logic [7:0]               char1;
      logic                     two;
      logic [LINE_OUT_BITS-1:0] line;
   } pkt_type;

   typedef struct packed {
      logic not_empty;
      logic not_full;
   } queue_status_type;

endpackage

>>> hw/rtl/dcl_front.sv
// Front end of the directive config lexer: takes one text byte per word,
// tracks the lexer flags and line count, and builds event packets. Uses dcl_pkg.
`timescale 1ns / 1ps
`include "directive_config_lexer_macros.svh"

module dcl_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic [7:0]                      byte_value,
   input  logic                            end_of_text,
   output logic                            push,
   output dcl_pkg::pkt_type                push_pkt
);
   import dcl_pkg::*;

   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;

   typedef struct packed {
      logic in_comment;
      logic skip_next;
      logic held_backslash;
      logic after_quote;
      logic between_tokens;
      logic in_double;
      logic in_single;
      logic has_words;
   } lex_flags_type;

   localparam lex_flags_type TOKEN_RESET = '{
      in_comment: 1'b0, skip_next: 1'b0, held_backslash: 1'b0, after_quote: 1'b0,
      between_tokens: 1'b1, in_double: 1'b0, in_single: 1'b0, has_words: 1'b0};

   lex_flags_type          flags_ff, flags_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic                   halted_ff, halted_in;

   logic                   is_lf;
   logic                   is_blank;
   logic                   comment_live;
   logic [LINE_BITS-1:0]   line_step;

   // classify the byte
   assign is_lf        = (byte_value == CH_LF);
   assign is_blank     = (byte_value == CH_SPACE) || (byte_value == CH_TAB) ||
                         (byte_value == CH_CR) || is_lf;
   assign comment_live = flags_ff.in_comment && !is_lf;
   assign line_step    = is_lf ? (line_ff + 1'b1) : line_ff;

   // next flags and event packet
   always_comb begin
      flags_in        = flags_ff;
      line_in         = line_ff;
      halted_in       = halted_ff;
      push            = 1'b0;
      push_pkt.kind0  = EV_CHAR;
      push_pkt.char0  = 8'h00;
      push_pkt.kind1  = EV_CHAR;
      push_pkt.char1  = 8'h00;
      push_pkt.two    = 1'b0;
      push_pkt.line   = LINE_OUT_BITS'(line_ff);

      if (accept) begin
         if (end_of_text) begin
            push           = 1'b1;
            push_pkt.kind0 = (!halted_ff && (flags_ff.has_words || !flags_ff.between_tokens))
                             ? EV_ERR : EV_END;
            flags_in       = TOKEN_RESET;
            line_in        = '0;
            halted_in      = 1'b0;
         end else if (!halted_ff) begin
            line_in       = line_step;
            push_pkt.line = LINE_OUT_BITS'(line_step);
            if (is_lf) begin
               flags_in.in_comment = 1'b0;
            end
            if (!comment_live) begin
               priority if (flags_ff.skip_next) begin
                  // resolve the escape pair
                  flags_in.skip_next      = 1'b0;
                  flags_in.held_backslash = 1'b0;
                  push                    = 1'b1;
                  priority if (byte_value == CH_DQUOTE || byte_value == CH_SQUOTE ||
                               byte_value == CH_BSLASH) begin
                     push_pkt.char0 = byte_value;
                  end else if (byte_value == CH_LOW_T) begin
                     push_pkt.char0 = CH_TAB;
                  end else if (byte_value == CH_LOW_R) begin
                     push_pkt.char0 = CH_CR;
                  end else if (byte_value == CH_LOW_N) begin
                     push_pkt.char0 = CH_LF;
                  end else begin
                     push_pkt.char0 = CH_BSLASH;
                     push_pkt.two   = 1'b1;
                     push_pkt.char1 = byte_value;
                  end
               end else if (flags_ff.after_quote) begin
                  // only a blank, ';' or '{' may follow a closing quote
                  priority if (is_blank) begin
                     flags_in.after_quote    = 1'b0;
                     flags_in.between_tokens = 1'b1;
                  end else if (byte_value == CH_SEMI) begin
                     push           = 1'b1;
                     push_pkt.kind0 = EV_STMT;
                     flags_in       = TOKEN_RESET;
                  end else if (byte_value == CH_LBRACE) begin
                     push           = 1'b1;
                     push_pkt.kind0 = EV_BLOCK;
                     flags_in       = TOKEN_RESET;
                  end else begin
                     push           = 1'b1;
                     push_pkt.kind0 = EV_ERR;
                     halted_in      = 1'b1;
                  end
               end else if (flags_ff.between_tokens) begin
                  priority if (is_blank) begin
                     flags_in = flags_in;
                  end else if (byte_value == CH_SEMI || byte_value == CH_LBRACE) begin
                     push = 1'b1;
                     if (!flags_ff.has_words) begin
                        push_pkt.kind0 = EV_ERR;
                        halted_in      = 1'b1;
                     end else begin
                        push_pkt.kind0 = (byte_value == CH_LBRACE) ? EV_BLOCK : EV_STMT;
                        flags_in       = TOKEN_RESET;
                     end
                  end else if (byte_value == CH_RBRACE) begin
                     push = 1'b1;
                     if (flags_ff.has_words) begin
                        push_pkt.kind0 = EV_ERR;
                        halted_in      = 1'b1;
                     end else begin
                        push_pkt.kind0 = EV_DONE;
                        flags_in       = TOKEN_RESET;
                     end
                  end else if (byte_value == CH_HASH) begin
                     flags_in.in_comment = 1'b1;
                  end else if (byte_value == CH_BSLASH) begin
                     flags_in.skip_next      = 1'b1;
                     flags_in.held_backslash = 1'b1;
                     flags_in.between_tokens = 1'b0;
                  end else if (byte_value == CH_DQUOTE) begin
                     flags_in.in_double      = 1'b1;
                     flags_in.between_tokens = 1'b0;
                  end else if (byte_value == CH_SQUOTE) begin
                     flags_in.in_single      = 1'b1;
                     flags_in.between_tokens = 1'b0;
                  end else begin
                     flags_in.between_tokens = 1'b0;
                     push                    = 1'b1;
                     push_pkt.char0          = byte_value;
                  end
               end else if (byte_value == CH_BSLASH) begin
                  flags_in.skip_next      = 1'b1;
                  flags_in.held_backslash = 1'b1;
                  flags_in.between_tokens = 1'b0;
               end else if (flags_ff.in_double || flags_ff.in_single) begin
                  // inside quotes: close on the matching quote, else pass through
                  push = 1'b1;
                  if ((flags_ff.in_double && byte_value == CH_DQUOTE) ||
                      (flags_ff.in_single && byte_value == CH_SQUOTE)) begin
                     flags_in.in_double   = 1'b0;
                     flags_in.in_single   = 1'b0;
                     flags_in.after_quote = 1'b1;
                     flags_in.has_words   = 1'b1;
                     push_pkt.kind0       = EV_WEND;
                  end else begin
                     push_pkt.char0 = byte_value;
                  end
               end else if (is_blank) begin
                  push                    = 1'b1;
                  push_pkt.kind0          = EV_WEND;
                  flags_in.has_words      = 1'b1;
                  flags_in.between_tokens = 1'b1;
               end else if (byte_value == CH_SEMI || byte_value == CH_LBRACE) begin
                  push           = 1'b1;
                  push_pkt.kind0 = EV_WEND;
                  push_pkt.two   = 1'b1;
                  push_pkt.kind1 = (byte_value == CH_LBRACE) ? EV_BLOCK : EV_STMT;
                  flags_in       = TOKEN_RESET;
               end else begin
                  push           = 1'b1;
                  push_pkt.char0 = byte_value;
               end
            end
         end
      end
   end

   // hold lexer state
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff  <= TOKEN_RESET;
         line_ff   <= '0;
         halted_ff <= 1'b0;
      end else begin
         flags_ff  <= flags_in;
         line_ff   <= line_in;
         halted_ff <= halted_in;
      end
   end

   // a halted lexer stays silent until end of text
   `DCL_ASSERT_IMP(a_halted_silent, clock, reset, halted_ff && accept && !end_of_text, !push)
   // an error on a text byte halts the lexer
   `DCL_ASSERT_NXT(a_error_halts, clock, reset,
      push && !end_of_text && push_pkt.kind0 == EV_ERR, halted_ff)

endmodule

>>> hw/rtl/dcl_queue.sv
// Short event-packet queue between the lexer front and the output back.
// Register-based circular buffer; uses dcl_pkg.
`timescale 1ns / 1ps
`include "directive_config_lexer_macros.svh"

module dcl_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  dcl_pkg::pkt_type           push_pkt,
   input  logic                       pop,
   output dcl_pkg::pkt_type           head_pkt,
   output dcl_pkg::queue_status_type  status
);
   import dcl_pkg::*;

   pkt_type               entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]  count_ff, count_in;

   // advance pointers with wrap
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : (wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : (rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the packet
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_pkt;
      end
   end

   assign head_pkt         = entry_ff[rd_ptr_ff];
   assign status.not_empty = (count_ff != '0);
   assign status.not_full  = (count_ff != QCNT_BITS'(QUEUE_DEPTH));

   // never write a full queue
   `DCL_ASSERT_IMP(a_no_overflow, clock, reset, push && !pop, status.not_full)

endmodule

>>> hw/rtl/dcl_back.sv
// Back end of the directive config lexer: walks each queued packet out as
// one or two result words on the rsp stream. Uses dcl_pkg.
`timescale 1ns / 1ps
`include "directive_config_lexer_macros.svh"

module dcl_back (
   input  logic                                   clock,
   input  logic                                   reset,
   input  dcl_pkg::pkt_type                       head_pkt,
   input  dcl_pkg::queue_status_type              status,
   output logic                                   pop,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [dcl_pkg::RSP_DATA_BITS-1:0]      rsp_tdata,
   output logic [dcl_pkg::RSP_USER_BITS-1:0]      rsp_tuser,
   output logic                                   rsp_tlast
);
   import dcl_pkg::*;

   logic       phase_ff, phase_in;
   logic       handshake;
   logic [7:0] char_sel;

   assign rsp_tvalid = status.not_empty;
   assign handshake  = rsp_tvalid && rsp_tready;

   // pick the first or second event of the head packet
   assign rsp_tlast  = phase_ff || !head_pkt.two;
   assign rsp_tuser  = phase_ff ? head_pkt.kind1 : head_pkt.kind0;
   assign char_sel   = phase_ff ? head_pkt.char1 : head_pkt.char0;
   assign rsp_tdata  = {head_pkt.line, char_sel};

   // drop the packet after its last word
   assign pop      = handshake && rsp_tlast;
   assign phase_in = handshake ? !rsp_tlast : phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // second word only for a two-event packet still at the head
   `DCL_ASSERT_IMP(a_phase_valid, clock, reset, phase_ff, status.not_empty && head_pkt.two)

endmodule

>>> hw/rtl/directive_config_lexer.sv
// Directive config lexer: one text byte per word in, token events out.
// The event packet of a taken byte is registered in the queue and reaches rsp once it is at the queue head.
// Throughput: one byte per cycle while the queue has room; a byte that yields two events holds its
// packet at the head for both output words, and a four-packet queue absorbs the difference.
// Reset (synchronous, active high) empties the queue, clears the line count and
// returns the lexer to the between-tokens state. Uses dcl_pkg, dcl_front/queue/back.
`timescale 1ns / 1ps

module directive_config_lexer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [dcl_pkg::REQ_DATA_BITS-1:0]    req_tdata,   // [7:0] byte_value
   input  logic                                 req_tuser,   // [0] end_of_text
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [dcl_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,   // [7:0] char_value, [31:8] line_number
   output logic [dcl_pkg::RSP_USER_BITS-1:0]    rsp_tuser,   // [2:0] event_kind
   output logic                                 rsp_tlast    // last_of_run
);
   import dcl_pkg::*;

   logic              accept;
   logic              push;
   logic              pop;
   pkt_type           push_pkt;
   pkt_type           head_pkt;
   queue_status_type  q_status;

   // take a word whenever the queue has room
   assign req_tready = q_status.not_full;
   assign accept     = req_tvalid && req_tready;

   dcl_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .byte_value  (req_tdata[7:0]),
      .end_of_text (req_tuser),
      .push        (push),
      .push_pkt    (push_pkt)
   );

   dcl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_pkt (push_pkt),
      .pop      (pop),
      .head_pkt (head_pkt),
      .status   (q_status)
   );

   dcl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_pkt   (head_pkt),
      .status     (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
